@@ design/mt19937_random_word_generator_assert.svh @@
// Assertion macros for the generator's RTL files.
// Both macros sample on the rising edge of clock.
`ifndef MT19937_RANDOM_WORD_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_WORD_GENERATOR_ASSERT_SVH

// Checked only while reset is low.
`define MTG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/mtg_pkg.sv @@
`default_nettype none

package mtg_pkg;

   // State vector geometry.
   localparam int StateDepth  = 624;
   localparam int IndexWidth  = $clog2(StateDepth);
   localparam int WordWidth   = 32;
   localparam int TwistOffset = 397;
   localparam int TwistSpan   = StateDepth - TwistOffset;
   localparam int LastIndex   = StateDepth - 1;

   // Recurrence, tempering and seeding constants.
   localparam logic [WordWidth-1:0] TwistMatrix   = 32'h9908b0df;
   localparam logic [WordWidth-1:0] TemperMaskB   = 32'h9d2c5680;
   localparam logic [WordWidth-1:0] TemperMaskC   = 32'hefc60000;
   localparam logic [WordWidth-1:0] LcgMultiplier = 32'd69069;
   localparam logic [WordWidth-1:0] LcgIncrement  = 32'd1;
   localparam logic [WordWidth-1:0] SeedDefault   = 32'd4357;

   // Output tempering of one state word.
   function automatic logic [WordWidth-1:0] temper(input logic [WordWidth-1:0] word);
      logic [WordWidth-1:0] y;
      y = word;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TemperMaskB);
      y = y ^ ((y << 15) & TemperMaskC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

@@ design/mtg_if.sv @@
`default_nettype none

// Request channel: one beat asks for one word.
interface mtg_req_if;
   logic valid;
   logic ready;
   logic request;

   modport source (output valid, output request, input ready);
   modport sink (input valid, input request, output ready);
endinterface

// Result channel: one beat carries one tempered word.
interface mtg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ design/mtg_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module mtg_ram #(
   parameter int Width = 32,
   parameter int Depth = 624
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/mt19937_random_word_generator.sv @@
// An accepted request moves the sequencer to ST_CALC; the tempered word is registered
// for rsp_bus once the twist completes with the output register free. A new request
// is taken only in ST_IDLE, so each word is finished before the next request is taken.
// The first request after reset or a seed write first fills the state in ST_SEED (two
// multiply steps per entry) and passes through ST_FETCH before the twist. Reset is synchronous:
// seed returns to 4357, the state becomes unseeded, and the state RAM contents are not cleared.
`default_nettype none

`include "mt19937_random_word_generator_assert.svh"

module mt19937_random_word_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   mtg_req_if.sink          req_bus,
   mtg_rsp_if.source        rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_FETCH,
      ST_CALC
   } state_type;

   state_type                            state_ff;
   logic                                 seeded_ff;
   logic [mtg_pkg::WordWidth-1:0]        seed_ff;
   logic [mtg_pkg::IndexWidth-1:0]       k_ff;
   logic [mtg_pkg::WordWidth-1:0]        cur_ff;
   logic [mtg_pkg::WordWidth-1:0]        lcg_ff;
   logic [mtg_pkg::WordWidth/2-1:0]      hi_ff;
   logic                                 phase_ff;
   logic                                 rsp_valid_ff;
   logic [mtg_pkg::WordWidth-1:0]        rsp_word_ff;

   logic [mtg_pkg::WordWidth-1:0]        lcg_in;
   logic [mtg_pkg::WordWidth-1:0]        seed_word;
   logic [mtg_pkg::IndexWidth-1:0]       nxt_idx;
   logic [mtg_pkg::IndexWidth-1:0]       far_idx;
   logic [mtg_pkg::WordWidth-1:0]        nxt_rd;
   logic [mtg_pkg::WordWidth-1:0]        far_rd;
   logic [mtg_pkg::WordWidth-1:0]        mix_word;
   logic [mtg_pkg::WordWidth-1:0]        twisted;
   logic                                 advance;
   logic                                 wr_en;
   logic [mtg_pkg::WordWidth-1:0]        wr_data;
   logic                                 last_index;

   // Neighbor and far addresses of the entry at the current index.
   assign last_index = (k_ff == mtg_pkg::IndexWidth'(mtg_pkg::LastIndex));
   assign nxt_idx    = last_index ? '0 : k_ff + mtg_pkg::IndexWidth'(1);
   assign far_idx    = (k_ff < mtg_pkg::IndexWidth'(mtg_pkg::TwistSpan))
                       ? k_ff + mtg_pkg::IndexWidth'(mtg_pkg::TwistOffset)
                       : k_ff - mtg_pkg::IndexWidth'(mtg_pkg::TwistSpan);

   // One linear congruential step per cycle while seeding.
   assign lcg_in    = lcg_ff * mtg_pkg::LcgMultiplier + mtg_pkg::LcgIncrement;
   assign seed_word = {hi_ff, lcg_ff[mtg_pkg::WordWidth-1:mtg_pkg::WordWidth/2]};

   // Twist of the current entry; cur_ff holds its value ahead of time.
   assign mix_word = {cur_ff[mtg_pkg::WordWidth-1], nxt_rd[mtg_pkg::WordWidth-2:0]};
   assign twisted  = far_rd ^ (mix_word >> 1) ^ (mix_word[0] ? mtg_pkg::TwistMatrix : '0);

   // The twist completes once the output register is free.
   assign advance = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_bus.ready);

   // Both state copies take the same writes.
   assign wr_en   = ((state_ff == ST_SEED) && phase_ff) || advance;
   assign wr_data = (state_ff == ST_SEED) ? seed_word : twisted;

   // Copy read at the following entry.
   mtg_ram #(
      .Width (mtg_pkg::WordWidth),
      .Depth (mtg_pkg::StateDepth)
   ) u_ram_next (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (k_ff),
      .wr_data (wr_data),
      .rd_addr (nxt_idx),
      .rd_data (nxt_rd)
   );

   // Copy read at the entry one offset ahead.
   mtg_ram #(
      .Width (mtg_pkg::WordWidth),
      .Depth (mtg_pkg::StateDepth)
   ) u_ram_far (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (k_ff),
      .wr_data (wr_data),
      .rd_addr (far_idx),
      .rd_data (far_rd)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.random_word = rsp_word_ff;

   // Sequencer with the seed register and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         seed_ff      <= mtg_pkg::SeedDefault;
         k_ff         <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register fills on a finished twist and empties on a taken beat.
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_enable) begin
            seed_ff   <= csr_write_data;
            seeded_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid && req_bus.request) begin
                  if (seeded_ff) begin
                     state_ff <= ST_CALC;
                  end else begin
                     state_ff <= ST_SEED;
                     lcg_ff   <= seed_ff;
                     k_ff     <= '0;
                     phase_ff <= 1'b0;
                  end
               end
            end

            ST_SEED: begin
               lcg_ff   <= lcg_in;
               phase_ff <= !phase_ff;
               if (!phase_ff) begin
                  hi_ff <= lcg_ff[mtg_pkg::WordWidth-1:mtg_pkg::WordWidth/2];
               end else begin
                  if (k_ff == '0) begin
                     cur_ff <= seed_word;
                  end
                  if (last_index) begin
                     k_ff      <= '0;
                     seeded_ff <= 1'b1;
                     state_ff  <= ST_FETCH;
                  end else begin
                     k_ff <= k_ff + mtg_pkg::IndexWidth'(1);
                  end
               end
            end

            ST_FETCH: begin
               state_ff <= ST_CALC;
            end

            ST_CALC: begin
               if (advance) begin
                  rsp_word_ff  <= mtg_pkg::temper(twisted);
                  cur_ff       <= nxt_rd;
                  k_ff         <= nxt_idx;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `MTG_ASSERT(a_write_apart_from_reads,
      advance |-> (nxt_idx != k_ff && far_idx != k_ff), "twist write hits a read address")
   `MTG_ASSERT(a_calc_needs_seed,
      (state_ff == ST_CALC) |-> seeded_ff, "twist started on unseeded state")
   `MTG_ASSERT(a_seed_from_fill,
      $rose(seeded_ff) |-> $past(state_ff == ST_SEED), "state marked seeded without a fill")
   `MTG_ASSERT(a_result_after_twist,
      advance |=> rsp_valid_ff, "twist finished without a result beat")
   `MTG_ASSERT_ALWAYS(a_reset_clears_output,
      reset |=> !rsp_valid_ff, "result pending after reset")

endmodule

`default_nettype wire
